@@ src/c2davg_pkg.sv @@
package c2davg_pkg;

    localparam int OP_W        = 2;
    localparam int COORD_W     = 6;
    localparam int VAL_W       = 16;
    localparam int PROD_W      = 2 * VAL_W;
    localparam int SUM_W       = 48;
    localparam int FEAT_W      = 32;
    localparam int FRAC_W      = 16;
    localparam int RECIP_W     = 17;
    localparam int DIM_W       = 7;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;
    localparam int S_TDATA_W   = 32;
    localparam int M_TDATA_W   = 48;
    // Position arithmetic width: holds a coordinate plus the kernel half-width,
    // and the largest plane size in use.
    localparam int POS_W       = 10;

    localparam logic [RECIP_W-1:0] RECIP_ONE   = RECIP_W'(65536);
    localparam logic [DIM_W-1:0]   DIM_RESET   = DIM_W'(64);
    localparam logic [SUM_W-1:0]   SUM_MAX     = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic [SUM_W-1:0]   SUM_MIN     = {1'b1, {(SUM_W-1){1'b0}}};
    localparam logic [FEAT_W-1:0]  FEAT_MAX    = {1'b0, {(FEAT_W-1){1'b1}}};
    localparam logic [FEAT_W-1:0]  FEAT_MIN    = {1'b1, {(FEAT_W-1){1'b0}}};

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR = 2'd0,
        OP_LOAD  = 2'd1,
        OP_PIXEL = 2'd2,
        OP_READ  = 2'd3
    } op_t;

    localparam logic [CFG_INDEX_W-1:0] CFG_BIAS   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_RECIP  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_WIDTH  = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_HEIGHT = 2'd3;

    typedef struct packed {
        logic [FEAT_W-1:0]  bias;
        logic [RECIP_W-1:0] recip;
        logic [DIM_W-1:0]   width;
        logic [DIM_W-1:0]   height;
    } cfg_t;

    // Output read request: the stored sum (zero outside the plane) and its position.
    typedef struct packed {
        logic               valid;
        logic [SUM_W-1:0]   sum;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
    } rd_req_t;

endpackage

@@ src/c2davg_ram.sv @@
module c2davg_ram #(
    parameter int DATA_W = 16,
    parameter int ADDR_W = 4
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [2**ADDR_W];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge aclk) begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ src/c2davg_engine.sv @@
module c2davg_engine import c2davg_pkg::*; #(
    parameter int KERNEL_SIZE = 3,
    parameter int MAX_DIM     = 64
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  cfg_t               cfg,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  op_t                s_op,
    input  logic [COORD_W-1:0] s_row,
    input  logic [COORD_W-1:0] s_col,
    input  logic [VAL_W-1:0]   s_value,
    output rd_req_t            rd_req,
    input  logic               rd_done
);

    localparam int CW   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int AW   = 2 * CW;
    localparam int TAPS = KERNEL_SIZE * KERNEL_SIZE;
    localparam int WAW  = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int KW   = $clog2(KERNEL_SIZE + 1);
    localparam int HALF = KERNEL_SIZE / 2;

    localparam logic [KW-1:0]    K_LAST   = KW'(KERNEL_SIZE - 1);
    localparam logic [WAW-1:0]   K_W      = WAW'(KERNEL_SIZE);
    localparam logic [WAW-1:0]   TAP_LAST = WAW'(TAPS - 1);
    localparam logic [POS_W-1:0] K_POS    = POS_W'(KERNEL_SIZE);
    localparam logic [POS_W-1:0] HALF_POS = POS_W'(HALF);
    localparam logic [POS_W-1:0] DIM_MAX  = POS_W'(MAX_DIM);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCATTER,
        ST_DRAIN,
        ST_READ,
        ST_WAIT
    } state_t;

    state_t              state_reg, state_next;
    logic [AW-1:0]       clr_cnt_reg, clr_cnt_next;
    logic [COORD_W-1:0]  row_reg, row_next;
    logic [COORD_W-1:0]  col_reg, col_next;
    logic [VAL_W-1:0]    pix_reg, pix_next;
    logic                inside_reg, inside_next;
    logic [KW-1:0]       a_reg, a_next;
    logic [KW-1:0]       b_reg, b_next;
    logic [WAW-1:0]      widx_reg, widx_next;
    logic [TAPS-1:0]     w_loaded_reg, w_loaded_next;
    logic                wv_reg, wv_next;
    logic                s1_we_reg, s1_we_next;
    logic [AW-1:0]       s1_addr_reg, s1_addr_next;
    logic                s2_we_reg, s2_we_next;
    logic [AW-1:0]       s2_addr_reg, s2_addr_next;
    logic [PROD_W-1:0]   prod_reg, prod_next;

    logic [POS_W-1:0]    h_use, w_use;
    logic [POS_W-1:0]    in_row_pos, in_col_pos;
    logic [POS_W-1:0]    i_pos, j_pos;
    logic [AW-1:0]       in_addr;
    logic                in_plane;
    logic                in_kernel;

    logic                wt_we;
    logic [WAW-1:0]      wt_waddr;
    logic [VAL_W-1:0]    wt_rdata;
    logic [VAL_W-1:0]    w_eff;

    logic                sum_we;
    logic [AW-1:0]       sum_waddr;
    logic [SUM_W-1:0]    sum_wdata;
    logic [AW-1:0]       sum_raddr;
    logic [SUM_W-1:0]    sum_rdata;
    logic [SUM_W:0]      sum_wide;
    logic [SUM_W-1:0]    sum_sat;

    c2davg_ram #(
        .DATA_W (VAL_W),
        .ADDR_W (WAW)
    ) u_weight_ram (
        .aclk  (aclk),
        .we    (wt_we),
        .waddr (wt_waddr),
        .wdata (s_value),
        .raddr (widx_reg),
        .rdata (wt_rdata)
    );

    c2davg_ram #(
        .DATA_W (SUM_W),
        .ADDR_W (AW)
    ) u_sum_ram (
        .aclk  (aclk),
        .we    (sum_we),
        .waddr (sum_waddr),
        .wdata (sum_wdata),
        .raddr (sum_raddr),
        .rdata (sum_rdata)
    );

    // Plane size in use, and where the incoming item falls.
    always_comb begin
        h_use      = (POS_W'(cfg.height) > DIM_MAX) ? DIM_MAX : POS_W'(cfg.height);
        w_use      = (POS_W'(cfg.width) > DIM_MAX) ? DIM_MAX : POS_W'(cfg.width);
        in_row_pos = POS_W'(s_row);
        in_col_pos = POS_W'(s_col);
        in_plane   = (in_row_pos < h_use) && (in_col_pos < w_use);
        in_kernel  = (in_row_pos < K_POS) && (in_col_pos < K_POS);
        in_addr    = {in_row_pos[CW-1:0], in_col_pos[CW-1:0]};
        wt_waddr   = WAW'(s_row) * K_W + WAW'(s_col);
        // Output position hit by the current tap; negative values wrap high.
        i_pos      = POS_W'(row_reg) + HALF_POS - POS_W'(a_reg);
        j_pos      = POS_W'(col_reg) + HALF_POS - POS_W'(b_reg);
    end

    // Second read stage: weight times pixel. Third stage: add and saturate.
    always_comb begin
        w_eff     = wv_reg ? wt_rdata : '0;
        prod_next = PROD_W'($signed(pix_reg) * $signed(w_eff));
        sum_wide  = {sum_rdata[SUM_W-1], sum_rdata}
                  + {{(SUM_W+1-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
        if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
            sum_sat = sum_wide[SUM_W] ? SUM_MIN : SUM_MAX;
        end else begin
            sum_sat = sum_wide[SUM_W-1:0];
        end
    end

    always_comb begin
        state_next    = state_reg;
        clr_cnt_next  = clr_cnt_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        pix_next      = pix_reg;
        inside_next   = inside_reg;
        a_next        = a_reg;
        b_next        = b_reg;
        widx_next     = widx_reg;
        w_loaded_next = w_loaded_reg;
        wv_next       = wv_reg;
        s1_we_next    = 1'b0;
        s1_addr_next  = s1_addr_reg;
        s2_we_next    = s1_we_reg;
        s2_addr_next  = s1_addr_reg;
        wt_we         = 1'b0;
        sum_we        = s2_we_reg;
        sum_waddr     = s2_addr_reg;
        sum_wdata     = sum_sat;
        sum_raddr     = s1_addr_reg;

        case (state_reg)
            ST_CLEAR: begin
                sum_we    = 1'b1;
                sum_waddr = clr_cnt_reg;
                sum_wdata = '0;
                if (&clr_cnt_reg) begin
                    state_next = ST_IDLE;
                end else begin
                    clr_cnt_next = clr_cnt_reg + 1'b1;
                end
            end
            ST_IDLE: begin
                sum_raddr = in_addr;
                if (s_tvalid) begin
                    case (s_op)
                        OP_CLEAR: begin
                            clr_cnt_next = '0;
                            state_next   = ST_CLEAR;
                        end
                        OP_LOAD: begin
                            if (in_kernel) begin
                                wt_we                   = 1'b1;
                                w_loaded_next[wt_waddr] = 1'b1;
                            end
                        end
                        OP_PIXEL: begin
                            if (in_plane) begin
                                row_next   = s_row;
                                col_next   = s_col;
                                pix_next   = s_value;
                                a_next     = '0;
                                b_next     = '0;
                                widx_next  = TAP_LAST;
                                state_next = ST_SCATTER;
                            end
                        end
                        OP_READ: begin
                            row_next    = s_row;
                            col_next    = s_col;
                            inside_next = in_plane;
                            state_next  = ST_READ;
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SCATTER: begin
                s1_we_next   = (i_pos < h_use) && (j_pos < w_use);
                s1_addr_next = {i_pos[CW-1:0], j_pos[CW-1:0]};
                wv_next      = w_loaded_reg[widx_reg];
                widx_next    = widx_reg - 1'b1;
                if (b_reg == K_LAST) begin
                    b_next = '0;
                    if (a_reg == K_LAST) begin
                        state_next = ST_DRAIN;
                    end else begin
                        a_next = a_reg + 1'b1;
                    end
                end else begin
                    b_next = b_reg + 1'b1;
                end
            end
            ST_DRAIN: begin
                if (!s1_we_reg) begin
                    state_next = ST_IDLE;
                end
            end
            ST_READ: begin
                state_next = ST_WAIT;
            end
            ST_WAIT: begin
                if (rd_done) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_cnt_reg  <= '0;
            w_loaded_reg <= '0;
            s1_we_reg    <= 1'b0;
            s2_we_reg    <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_cnt_reg  <= clr_cnt_next;
            w_loaded_reg <= w_loaded_next;
            s1_we_reg    <= s1_we_next;
            s2_we_reg    <= s2_we_next;
        end
        row_reg     <= row_next;
        col_reg     <= col_next;
        pix_reg     <= pix_next;
        inside_reg  <= inside_next;
        a_reg       <= a_next;
        b_reg       <= b_next;
        widx_reg    <= widx_next;
        wv_reg      <= wv_next;
        s1_addr_reg <= s1_addr_next;
        s2_addr_reg <= s2_addr_next;
        prod_reg    <= prod_next;
    end

    assign s_tready     = (state_reg == ST_IDLE);
    assign rd_req.valid = (state_reg == ST_READ);
    assign rd_req.sum   = inside_reg ? sum_rdata : '0;
    assign rd_req.row   = row_reg;
    assign rd_req.col   = col_reg;

endmodule

@@ src/c2davg_readout.sv @@
module c2davg_readout import c2davg_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  cfg_t               cfg,
    input  rd_req_t            rd_req,
    output logic               rd_done,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [FEAT_W-1:0]  m_feature,
    output logic [COORD_W-1:0] m_row,
    output logic [COORD_W-1:0] m_col
);

    localparam int LO_W    = SUM_W / 2;
    localparam int HI_W    = SUM_W - LO_W;
    localparam int PLO_W   = LO_W + RECIP_W;
    localparam int PHI_W   = HI_W + RECIP_W + 1;
    localparam int TOT_W   = PHI_W + LO_W;
    localparam int SHIFT_W = TOT_W - FRAC_W;
    localparam int Q_W     = SHIFT_W + 1;

    localparam logic [TOT_W-1:0] ROUND_HALF = TOT_W'(2**(FRAC_W - 1));

    logic [RECIP_W-1:0]       rc;
    logic [PLO_W-1:0]         plo_reg, plo_next;
    logic signed [PHI_W-1:0]  phi_reg, phi_next;
    logic [TOT_W-1:0]         rnd_reg, total;
    logic                     r1_vld_reg, r2_vld_reg, r2_vld_next;
    logic [COORD_W-1:0]       r1_row_reg, r1_col_reg;
    logic [COORD_W-1:0]       r2_row_reg, r2_col_reg;
    logic                     out_vld_reg, out_vld_next;
    logic [FEAT_W-1:0]        feat_reg;
    logic [COORD_W-1:0]       orow_reg, ocol_reg;
    logic [SHIFT_W-1:0]       shifted;
    logic [Q_W-1:0]           q;
    logic                     fits;
    logic [FEAT_W-1:0]        feat;
    logic                     load;

    // The 48 x 17 product is split into two narrower partial products.
    always_comb begin
        rc       = (cfg.recip > RECIP_ONE) ? RECIP_ONE : cfg.recip;
        plo_next = PLO_W'(rd_req.sum[LO_W-1:0]) * PLO_W'(rc);
        phi_next = $signed(rd_req.sum[SUM_W-1:LO_W]) * $signed({1'b0, rc});
        total    = {phi_reg, {LO_W{1'b0}}} + TOT_W'(plo_reg) + ROUND_HALF;
    end

    // Floor shift, bias and saturation to the output range.
    always_comb begin
        shifted = rnd_reg[TOT_W-1:FRAC_W];
        q       = {shifted[SHIFT_W-1], shifted}
                + {{(Q_W-FEAT_W){cfg.bias[FEAT_W-1]}}, cfg.bias};
        fits    = (&q[Q_W-1:FEAT_W-1]) || !(|q[Q_W-1:FEAT_W-1]);
        if (fits) begin
            feat = q[FEAT_W-1:0];
        end else begin
            feat = q[Q_W-1] ? FEAT_MIN : FEAT_MAX;
        end
        load         = r2_vld_reg && (!out_vld_reg || m_tready);
        r2_vld_next  = r1_vld_reg || (r2_vld_reg && !load);
        out_vld_next = load || (out_vld_reg && !m_tready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            r1_vld_reg  <= 1'b0;
            r2_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            r1_vld_reg  <= rd_req.valid;
            r2_vld_reg  <= r2_vld_next;
            out_vld_reg <= out_vld_next;
        end
        if (rd_req.valid) begin
            plo_reg    <= plo_next;
            phi_reg    <= phi_next;
            r1_row_reg <= rd_req.row;
            r1_col_reg <= rd_req.col;
        end
        if (r1_vld_reg) begin
            rnd_reg    <= total;
            r2_row_reg <= r1_row_reg;
            r2_col_reg <= r1_col_reg;
        end
        if (load) begin
            feat_reg <= feat;
            orow_reg <= r2_row_reg;
            ocol_reg <= r2_col_reg;
        end
    end

    assign rd_done   = load;
    assign m_tvalid  = out_vld_reg;
    assign m_feature = feat_reg;
    assign m_row     = orow_reg;
    assign m_col     = ocol_reg;

endmodule

@@ src/conv2d_channel_average.sv @@
// Same-size 2D convolution of one KERNEL_SIZE x KERNEL_SIZE kernel, averaged over
// input channels. The kernel is applied flipped by 180 degrees with zero padding of
// KERNEL_SIZE/2 on every side, so the output plane has the size of the input plane.
// Each input transaction carries an operation in s_tuser: clear all partial sums,
// load one kernel weight, scatter one Q8.8 pixel into the sums it touches, or read
// one output, which returns sum * recip_channels (rounded) + bias, saturated to
// Q16.16. Only reads produce an output transaction. Partial sums saturate at the
// signed 48-bit range and live in one synchronous RAM of MAX_DIM^2 entries (rounded
// up to a power of two per axis); kernel weights live in a small RAM of their own.
// Timing: a pixel inside the plane is scattered one tap per cycle, then a drain state
// lets the single read-modify-write pass through the sum RAM run out; a weight
// load or a pixel outside the plane is taken without leaving the idle state; a read
// goes through the readout multiplier pipeline. A clear, and the clearing pass after
// reset, sweep all 2^(2*ceil(log2(MAX_DIM))) sum RAM entries one entry per cycle,
// 4096 at the default size, during which no input transaction is accepted.
// Configuration writes are always accepted and must only be made while idle.
module conv2d_channel_average import c2davg_pkg::*; #(
    parameter int KERNEL_SIZE = 3,
    parameter int MAX_DIM     = 64
) (
    input  logic                   aclk,
    input  logic                   aresetn,

    // Configuration write channel: index 0 bias, 1 recip_channels,
    // 2 image_width, 3 image_height.
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,

    // Input stream.
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [S_TDATA_W-1:0]   s_tdata,  // row [5:0], col [11:6], value [27:12], zero fill
    input  logic [OP_W-1:0]        s_tuser,  // op [1:0]

    // Result stream.
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [M_TDATA_W-1:0]   m_tdata   // feature [31:0], out_row [37:32],
                                             // out_col [43:38], zero fill
);

    cfg_t               cfg_reg, cfg_next;
    rd_req_t            rd_req;
    logic               rd_done;
    logic [FEAT_W-1:0]  m_feature;
    logic [COORD_W-1:0] m_row, m_col;

    // Configuration registers. The port never stalls.
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                CFG_BIAS:   cfg_next.bias   = cfg_data[FEAT_W-1:0];
                CFG_RECIP:  cfg_next.recip  = cfg_data[RECIP_W-1:0];
                CFG_WIDTH:  cfg_next.width  = cfg_data[DIM_W-1:0];
                CFG_HEIGHT: cfg_next.height = cfg_data[DIM_W-1:0];
                default:    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.bias   <= '0;
            cfg_reg.recip  <= RECIP_ONE;
            cfg_reg.width  <= DIM_RESET;
            cfg_reg.height <= DIM_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg_ready = 1'b1;

    // Sequencer and the two RAMs: clears, weight loads, the pixel scatter pass,
    // and the sum lookup for reads.
    c2davg_engine #(
        .KERNEL_SIZE (KERNEL_SIZE),
        .MAX_DIM     (MAX_DIM)
    ) u_engine (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_op     (op_t'(s_tuser)),
        .s_row    (s_tdata[COORD_W-1:0]),
        .s_col    (s_tdata[2*COORD_W-1:COORD_W]),
        .s_value  (s_tdata[2*COORD_W+VAL_W-1:2*COORD_W]),
        .rd_req   (rd_req),
        .rd_done  (rd_done)
    );

    // Scaling, rounding, bias and saturation, ending in the output register, which
    // holds a finished result until the downstream side takes it.
    c2davg_readout u_readout (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .rd_req    (rd_req),
        .rd_done   (rd_done),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_feature (m_feature),
        .m_row     (m_row),
        .m_col     (m_col)
    );

    assign m_tdata = {{(M_TDATA_W-FEAT_W-2*COORD_W){1'b0}}, m_col, m_row, m_feature};

endmodule

@@ tb/sv/tb_conv2d_channel_average.sv @@
module tb_conv2d_channel_average;
    timeunit 1ns;
    timeprecision 1ps;

    import c2davg_pkg::*;

    // Geometry of the instance under test, passed down explicitly so that the
    // predictor below and the block cannot drift apart.
    localparam int KERNEL_SIZE = 3;
    localparam int MAX_DIM     = 64;
    localparam int HALF_K      = KERNEL_SIZE / 2;

    // The random part runs until this many transactions have done real work.
    localparam int RANDOM_ITEMS  = 1750;
    // Cycles to let pass once the last result is in, so that a trailing pixel
    // scatter can finish.
    localparam int SETTLE_CYCLES = 20;
    // A correct run spends most of its cycles in clearing sweeps.
    localparam int CYCLE_LIMIT   = 1_000_000;

    localparam longint SUM_HI  = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint SUM_LO  = -SUM_HI - 1;
    localparam longint FEAT_HI = 64'sh0000_0000_7FFF_FFFF;
    localparam longint FEAT_LO = -FEAT_HI - 1;

    // One input transaction, unpacked into its fields.
    typedef struct {
        op_t                op;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic [VAL_W-1:0]   value;
    } conv_item_t;

    // One result as it should appear on the master side.
    typedef struct {
        logic [FEAT_W-1:0]  feature;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
    } feature_t;

    // A row of the directed table is either an input transaction or a register
    // write. Item rows leave reg_index unused, register rows leave op, row and
    // col unused. Where pinned is set, the read's result is the one typed in
    // the row rather than the one the predictor works out.
    typedef enum logic { STEP_ITEM, STEP_REG } step_kind_t;

    typedef struct packed {
        step_kind_t             kind;
        op_t                    op;
        logic [CFG_INDEX_W-1:0] reg_index;
        logic [COORD_W-1:0]     row;
        logic [COORD_W-1:0]     col;
        logic [31:0]            data;
        logic                   pinned;
        logic [FEAT_W-1:0]      feature;
    } step_t;

    // ------------------------------------------------------------------------
    // Signals to and from the block. Every input starts at a known value.
    // ------------------------------------------------------------------------
    logic                   aclk;
    logic                   aresetn   = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata   = '0;   // row [5:0], col [11:6], value [27:12], zero fill
    logic [OP_W-1:0]        s_tuser   = '0;   // op [1:0]
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;          // feature [31:0], out_row [37:32],
                                              // out_col [43:38], zero fill

    // ------------------------------------------------------------------------
    // Predictor state: the kernel, the store of partial sums and the four
    // registers, all held at the widths the block uses.
    // ------------------------------------------------------------------------
    logic signed [VAL_W-1:0]  kernel_taps [KERNEL_SIZE*KERNEL_SIZE];
    logic signed [SUM_W-1:0]  sum_store   [MAX_DIM*MAX_DIM];
    logic signed [FEAT_W-1:0] bias_reg   = '0;
    logic [RECIP_W-1:0]       recip_reg  = RECIP_ONE;
    logic [DIM_W-1:0]         width_reg  = DIM_RESET;
    logic [DIM_W-1:0]         height_reg = DIM_RESET;

    // Reads whose results have not yet come back, oldest first.
    feature_t pending_features[$];
    int       mismatches = 0;
    // While set, neither side inserts idle cycles.
    bit       quiet = 1'b0;

    // The directed table. The opening reads land behind the clearing pass that
    // follows reset, so they also check that the pass leaves both corner sums at zero.
    step_t directed_steps[$] = '{
        // Straight out of reset: zero bias, zero sums, both plane corners.
        '{STEP_ITEM, OP_READ,  CFG_BIAS,   6'd0,  6'd0,  32'h0000_0000, 1'b1, 32'h0000_0000},
        '{STEP_ITEM, OP_READ,  CFG_BIAS,   6'd63, 6'd63, 32'h0000_0000, 1'b1, 32'h0000_0000},
        // Kernel: 1.0 in the centre, both extremes and -1/256 in three corners.
        '{STEP_ITEM, OP_LOAD,  CFG_BIAS,   6'd1,  6'd1,  32'h0000_0100, 1'b0, 32'h0000_0000},
        '{STEP_ITEM, OP_LOAD,  CFG_BIAS,   6'd0,  6'd0,  32'h0000_7FFF, 1'b0, 32'h0000_0000},
        '{STEP_ITEM, OP_LOAD,  CFG_BIAS,   6'd2,  6'd2,  32'h0000_8000, 1'b0, 32'h0000_0000},
        '{STEP_ITEM, OP_LOAD,  CFG_BIAS,   6'd0,  6'd2,  32'h0000_FFFF, 1'b0, 32'h0000_0000},
        // Weight indices outside the kernel must be dropped.
        '{STEP_ITEM, OP_LOAD,  CFG_BIAS,   6'd3,  6'd1,  32'h0000_1234, 1'b0, 32'h0000_0000},
        '{STEP_ITEM, OP_LOAD,  CFG_BIAS,   6'd63, 6'd63, 32'h0000_5555, 1'b0, 32'h0000_0000},
        // 1.0 times the centre weight of 1.0 gives exactly 1.0 in Q16.16.
        '{STEP_ITEM, OP_PIXEL, CFG_BIAS,   6'd5,  6'd5,  32'h0000_0100, 1'b0, 32'h0000_0000},
        '{STEP_ITEM, OP_READ,  CFG_BIAS,   6'd5,  6'd5,  32'h0000_0000, 1'b1, 32'h0001_0000},
        // Pixels in both corners, where most taps fall into the zero padding.
        '{STEP_ITEM, OP_PIXEL, CFG_BIAS,   6'd0,  6'd0,  32'h0000_8000, 1'b0, 32'h0000_0000},
        '{STEP_ITEM, OP_PIXEL, CFG_BIAS,   6'd63, 6'd63, 32'h0000_7FFF, 1'b0, 32'h0000_0000},
        '{STEP_ITEM, OP_READ,  CFG_BIAS,   6'd63, 6'd63, 32'h0000_0000, 1'b0, 32'h0000_0000},
        '{STEP_ITEM, OP_READ,  CFG_BIAS,   6'd0,  6'd0,  32'h0000_0000, 1'b0, 32'h0000_0000},
        // A large positive sum at (20,20) and a large negative one at (21,21).
        '{STEP_ITEM, OP_PIXEL, CFG_BIAS,   6'd20, 6'd20, 32'h0000_7FFF, 1'b0, 32'h0000_0000},
        // The largest bias pushes the positive sum past the top of Q16.16.
        '{STEP_REG,  OP_CLEAR, CFG_BIAS,   6'd0,  6'd0,  32'h7FFF_FFFF, 1'b0, 32'h0000_0000},
        '{STEP_ITEM, OP_READ,  CFG_BIAS,   6'd20, 6'd20, 32'h0000_0000, 1'b1, 32'h7FFF_FFFF},
        // The smallest bias pushes the negative sum past the bottom.
        '{STEP_REG,  OP_CLEAR, CFG_BIAS,   6'd0,  6'd0,  32'h8000_0000, 1'b0, 32'h0000_0000},
        '{STEP_ITEM, OP_READ,  CFG_BIAS,   6'd21, 6'd21, 32'h0000_0000, 1'b1, 32'h8000_0000},
        // A zero reciprocal leaves nothing but the bias.
        '{STEP_REG,  OP_CLEAR, CFG_RECIP,  6'd0,  6'd0,  32'h0000_0000, 1'b0, 32'h0000_0000},
        '{STEP_ITEM, OP_READ,  CFG_BIAS,   6'd20, 6'd20, 32'h0000_0000, 1'b1, 32'h8000_0000},
        // The largest reciprocal the register holds is taken as 1.0.
        '{STEP_REG,  OP_CLEAR, CFG_RECIP,  6'd0,  6'd0,  32'h0001_FFFF, 1'b0, 32'h0000_0000},
        '{STEP_REG,  OP_CLEAR, CFG_BIAS,   6'd0,  6'd0,  32'h0000_0000, 1'b0, 32'h0000_0000},
        '{STEP_ITEM, OP_READ,  CFG_BIAS,   6'd5,  6'd5,  32'h0000_0000, 1'b1, 32'h0001_0000},
        // The smallest reciprocal exercises the rounding.
        '{STEP_REG,  OP_CLEAR, CFG_RECIP,  6'd0,  6'd0,  32'h0000_0001, 1'b0, 32'h0000_0000},
        '{STEP_ITEM, OP_READ,  CFG_BIAS,   6'd20, 6'd20, 32'h0000_0000, 1'b0, 32'h0000_0000},
        // A plane of zero width: pixels vanish and every read gives the bias.
        '{STEP_REG,  OP_CLEAR, CFG_WIDTH,  6'd0,  6'd0,  32'h0000_0000, 1'b0, 32'h0000_0000},
        '{STEP_ITEM, OP_PIXEL, CFG_BIAS,   6'd1,  6'd1,  32'h0000_7FFF, 1'b0, 32'h0000_0000},
        '{STEP_ITEM, OP_READ,  CFG_BIAS,   6'd5,  6'd5,  32'h0000_0000, 1'b1, 32'h0000_0000},
        // Width above the store's size, a single row in use.
        '{STEP_REG,  OP_CLEAR, CFG_WIDTH,  6'd0,  6'd0,  32'h0000_007F, 1'b0, 32'h0000_0000},
        '{STEP_REG,  OP_CLEAR, CFG_HEIGHT, 6'd0,  6'd0,  32'h0000_0001, 1'b0, 32'h0000_0000},
        '{STEP_ITEM, OP_PIXEL, CFG_BIAS,   6'd0,  6'd40, 32'h0000_0200, 1'b0, 32'h0000_0000},
        '{STEP_ITEM, OP_READ,  CFG_BIAS,   6'd0,  6'd40, 32'h0000_0000, 1'b0, 32'h0000_0000},
        // A clear wipes every sum; only the zero bias is left.
        '{STEP_REG,  OP_CLEAR, CFG_HEIGHT, 6'd0,  6'd0,  32'h0000_0040, 1'b0, 32'h0000_0000},
        '{STEP_ITEM, OP_CLEAR, CFG_BIAS,   6'd0,  6'd0,  32'h0000_0000, 1'b0, 32'h0000_0000},
        '{STEP_ITEM, OP_READ,  CFG_BIAS,   6'd20, 6'd20, 32'h0000_0000, 1'b1, 32'h0000_0000}
    };

    conv2d_channel_average #(
        .KERNEL_SIZE (KERNEL_SIZE),
        .MAX_DIM     (MAX_DIM)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // Predictor.
    // ------------------------------------------------------------------------

    // Rows or columns of the plane actually in use; the store caps both.
    function automatic int plane_size(logic [DIM_W-1:0] dim);
        return (dim > MAX_DIM) ? MAX_DIM : int'(dim);
    endfunction

    function automatic void clear_sums();
        foreach (sum_store[k]) sum_store[k] = '0;
    endfunction

    // A pixel at (r,c) feeds every output whose flipped kernel window covers
    // it. Taps that would land in the padding are skipped, and each sum is
    // held within the signed 48-bit range.
    function automatic void scatter_pixel(int r, int c, logic signed [VAL_W-1:0] pix);
        int     h;
        int     w;
        int     i;
        int     j;
        longint acc;
        h = plane_size(height_reg);
        w = plane_size(width_reg);
        if (r >= h || c >= w) return;
        for (int a = 0; a < KERNEL_SIZE; a++) begin
            for (int b = 0; b < KERNEL_SIZE; b++) begin
                i = r + HALF_K - a;
                j = c + HALF_K - b;
                if (i >= 0 && i < h && j >= 0 && j < w) begin
                    acc = longint'(sum_store[i*MAX_DIM + j]) + longint'(pix) *
                          longint'(kernel_taps[(KERNEL_SIZE-1-a)*KERNEL_SIZE +
                                               (KERNEL_SIZE-1-b)]);
                    if (acc > SUM_HI) acc = SUM_HI;
                    if (acc < SUM_LO) acc = SUM_LO;
                    sum_store[i*MAX_DIM + j] = acc[SUM_W-1:0];
                end
            end
        end
    endfunction

    // Output at (r,c): the sum (zero outside the plane) scaled by the clamped
    // reciprocal, rounded half up by the shift, plus bias, saturated.
    function automatic logic [FEAT_W-1:0] averaged_feature(int r, int c);
        longint s;
        longint rc;
        longint q;
        s  = 0;
        rc = (recip_reg > RECIP_ONE) ? longint'(RECIP_ONE) : longint'(recip_reg);
        if (r < plane_size(height_reg) && c < plane_size(width_reg))
            s = longint'(sum_store[r*MAX_DIM + c]);
        q = ((s * rc + (longint'(1) <<< (FRAC_W - 1))) >>> FRAC_W) + longint'(bias_reg);
        if (q > FEAT_HI) q = FEAT_HI;
        if (q < FEAT_LO) q = FEAT_LO;
        return q[FEAT_W-1:0];
    endfunction

    // Coordinates mostly inside the plane or just past its edge, now and then
    // anywhere in the six-bit range.
    function automatic logic [COORD_W-1:0] pick_coord(logic [DIM_W-1:0] dim);
        int span;
        span = plane_size(dim);
        if (span > MAX_DIM - 1) span = MAX_DIM - 1;
        if ($urandom_range(0, 4) == 0) return COORD_W'($urandom_range(0, MAX_DIM - 1));
        return COORD_W'($urandom_range(0, span));
    endfunction

    // Register values across their whole field, the extremes favoured, but
    // mostly small planes so that pixels keep landing on the sums being read.
    function automatic logic [31:0] draw_dim();
        case ($urandom_range(0, 9))
            0:       return 32'd0;
            1:       return 32'(MAX_DIM);
            2:       return $urandom_range(MAX_DIM + 1, 2**DIM_W - 1);
            3:       return $urandom_range(1, MAX_DIM);
            default: return $urandom_range(1, 8);
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus side.
    // ------------------------------------------------------------------------

    // Presents one transaction after a random gap and applies it to the
    // predictor at the edge where it is taken. tvalid is left high, so that a
    // transaction following with no gap is driven in the very same step.
    task automatic send_item(conv_item_t it, bit pinned, logic [FEAT_W-1:0] pinned_feature);
        feature_t want;
        int       gap;
        gap = quiet ? 0 : $urandom_range(0, 4);
        cfg_valid <= 1'b0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.op;
        s_tdata  <= {{(S_TDATA_W - COORD_W*2 - VAL_W){1'b0}}, it.value, it.col, it.row};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        case (it.op)
            OP_CLEAR: clear_sums();
            OP_LOAD: begin
                if (it.row < KERNEL_SIZE && it.col < KERNEL_SIZE)
                    kernel_taps[it.row*KERNEL_SIZE + it.col] = it.value;
            end
            OP_PIXEL: scatter_pixel(it.row, it.col, it.value);
            OP_READ: begin
                want.feature = pinned ? pinned_feature : averaged_feature(it.row, it.col);
                want.row     = it.row;
                want.col     = it.col;
                pending_features.push_back(want);
            end
        endcase
    endtask

    // Register write. cfg_valid stays high afterwards so that back-to-back
    // writes follow each other directly; the next transaction or wait lowers it.
    task automatic write_register(logic [CFG_INDEX_W-1:0] idx, logic [31:0] data);
        s_tvalid  <= 1'b0;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            CFG_BIAS:   bias_reg   = data;
            CFG_RECIP:  recip_reg  = data[RECIP_W-1:0];
            CFG_WIDTH:  width_reg  = data[DIM_W-1:0];
            CFG_HEIGHT: height_reg = data[DIM_W-1:0];
        endcase
    endtask

    // Lets the block run dry: every pending read answered, then enough cycles
    // for a trailing pixel scatter to finish. Every phase ends on a read, so a
    // clearing sweep is always over by the time its result comes back.
    task automatic wait_idle();
        s_tvalid  <= 1'b0;
        cfg_valid <= 1'b0;
        while (pending_features.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    initial begin : stimulus
        conv_item_t  it;
        step_t       step;
        logic [31:0] data;
        bit          prev_reg;
        bit          all_regs;
        bit          ignored;
        int          counted;
        int          len;
        int          phase;

        foreach (kernel_taps[k]) kernel_taps[k] = '0;
        clear_sums();

        // Synchronous reset, held once, at the start.
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part: walk the table, letting the block go idle before
        // each group of register writes.
        prev_reg = 1'b0;
        foreach (directed_steps[n]) begin
            step = directed_steps[n];
            if (step.kind == STEP_REG) begin
                if (!prev_reg) wait_idle();
                write_register(step.reg_index, step.data);
            end else begin
                it.op    = step.op;
                it.row   = step.row;
                it.col   = step.col;
                it.value = step.data[VAL_W-1:0];
                send_item(it, step.pinned, step.feature);
            end
            prev_reg = (step.kind == STEP_REG);
        end

        // Random part, in phases. Each phase picks new settings, sometimes clears,
        // reloads some kernel taps, then streams a mix dominated by pixels and reads,
        // with a sprinkling of clears, out-of-kernel loads and off-plane pixels. Only
        // transactions that change or report something are counted.
        counted = 0;
        phase   = 0;
        while (counted < RANDOM_ITEMS) begin
            wait_idle();
            all_regs = (phase == 0);
            quiet    = ($urandom_range(0, 3) == 0);

            if (all_regs || $urandom_range(0, 1) == 1) begin
                case ($urandom_range(0, 5))
                    0:       data = 32'h7FFF_FFFF;
                    1:       data = 32'h8000_0000;
                    2:       data = $urandom();
                    default: data = $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
                endcase
                write_register(CFG_BIAS, data);
            end
            if (all_regs || $urandom_range(0, 1) == 1) begin
                case ($urandom_range(0, 7))
                    0:       data = 32'd0;
                    1:       data = 32'd1;
                    2:       data = 32'(RECIP_ONE);
                    3:       data = $urandom_range(RECIP_ONE + 1, 2**RECIP_W - 1);
                    4:       data = $urandom_range(1, RECIP_ONE);
                    default: data = RECIP_ONE / $urandom_range(1, 16);
                endcase
                write_register(CFG_RECIP, data);
            end
            if (all_regs || $urandom_range(0, 1) == 1) write_register(CFG_WIDTH, draw_dim());
            if (all_regs || $urandom_range(0, 1) == 1) write_register(CFG_HEIGHT, draw_dim());

            if ($urandom_range(0, 2) == 0) begin
                it.op    = OP_CLEAR;
                it.row   = COORD_W'($urandom());
                it.col   = COORD_W'($urandom());
                it.value = VAL_W'($urandom());
                send_item(it, 1'b0, '0);
                counted++;
            end

            for (int k = 0; k < KERNEL_SIZE*KERNEL_SIZE; k++) begin
                if (all_regs || $urandom_range(0, 1) == 1) begin
                    it.op    = OP_LOAD;
                    it.row   = COORD_W'(k / KERNEL_SIZE);
                    it.col   = COORD_W'(k % KERNEL_SIZE);
                    it.value = VAL_W'($urandom());
                    send_item(it, 1'b0, '0);
                    counted++;
                end
            end

            len = $urandom_range(60, 160);
            repeat (len) begin
                it.value = VAL_W'($urandom());
                case ($urandom_range(0, 99)) inside
                    [0:0]: begin
                        it.op  = OP_CLEAR;
                        it.row = COORD_W'($urandom());
                        it.col = COORD_W'($urandom());
                    end
                    [1:9]: begin
                        it.op = OP_LOAD;
                        if ($urandom_range(0, 5) == 0) begin
                            it.row = COORD_W'($urandom());
                            it.col = COORD_W'($urandom());
                        end else begin
                            it.row = COORD_W'($urandom_range(0, KERNEL_SIZE - 1));
                            it.col = COORD_W'($urandom_range(0, KERNEL_SIZE - 1));
                        end
                    end
                    [10:54]: begin
                        it.op  = OP_PIXEL;
                        it.row = pick_coord(height_reg);
                        it.col = pick_coord(width_reg);
                        if ($urandom_range(0, 9) == 0)
                            it.value = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
                    end
                    default: begin
                        it.op  = OP_READ;
                        it.row = pick_coord(height_reg);
                        it.col = pick_coord(width_reg);
                    end
                endcase
                ignored = (it.op == OP_LOAD &&
                           (it.row >= KERNEL_SIZE || it.col >= KERNEL_SIZE)) ||
                          (it.op == OP_PIXEL &&
                           (it.row >= plane_size(height_reg) ||
                            it.col >= plane_size(width_reg)));
                if (!ignored) counted++;
                send_item(it, 1'b0, '0);
            end

            // Closing read: once it is answered, all earlier work is done.
            it.op    = OP_READ;
            it.row   = pick_coord(height_reg);
            it.col   = pick_coord(width_reg);
            it.value = VAL_W'($urandom());
            send_item(it, 1'b0, '0);
            counted++;
            phase++;
        end

        // Drain, then give the block time to put out anything unexpected.
        s_tvalid <= 1'b0;
        while (pending_features.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("conv2d_channel_average: match");
        end else begin
            $display("conv2d_channel_average: mismatch");
        end
        $finish;
    end

    // ------------------------------------------------------------------------
    // Result side: stall a random number of cycles before each transaction
    // (none in quiet phases), then take it and compare it with the oldest
    // pending read. Outputs are sampled at the edge, before the block updates.
    // ------------------------------------------------------------------------
    initial begin : result_check
        feature_t           want;
        logic [FEAT_W-1:0]  got_feature;
        logic [COORD_W-1:0] got_row;
        logic [COORD_W-1:0] got_col;
        int                 stall;

        wait (aresetn === 1'b1);
        forever begin
            stall = quiet ? 0 : $urandom_range(0, 4);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (m_tvalid !== 1'b1) @(posedge aclk);
            got_feature = m_tdata[FEAT_W-1:0];
            got_row     = m_tdata[FEAT_W +: COORD_W];
            got_col     = m_tdata[FEAT_W + COORD_W +: COORD_W];
            if (pending_features.size() == 0) begin
                $error("unexpected result: feature %h at row %0d col %0d",
                       got_feature, got_row, got_col);
                mismatches++;
            end else begin
                want = pending_features.pop_front();
                if (got_feature !== want.feature) begin
                    $error("feature: expected %h, got %h", want.feature, got_feature);
                    mismatches++;
                end
                if (got_row !== want.row) begin
                    $error("out_row: expected %0d, got %0d", want.row, got_row);
                    mismatches++;
                end
                if (got_col !== want.col) begin
                    $error("out_col: expected %0d, got %0d", want.col, got_col);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial begin : watchdog
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("timed out after %0d cycles", CYCLE_LIMIT);
        $display("conv2d_channel_average: mismatch");
        $finish;
    end

endmodule
